// File: rtl/core/four_function_calculator_defines.svh
// assertion macros shared by the calculator rtl
// no dependencies; taken in by files that carry assertions
`ifndef FOUR_FUNCTION_CALCULATOR_DEFINES_SVH
`define FOUR_FUNCTION_CALCULATOR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define FFC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define FFC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/ffc_pkg.sv
// types, codes and constants of the four function calculator
// no dependencies; used by every calculator module
`default_nettype none

package ffc_pkg;

   localparam int unsigned QUEUE_DEPTH = 2;

   localparam logic [15:0] DIGIT_LIMIT = 16'd6553;
   localparam logic [3:0]  MAX_DIGIT   = 4'd9;
   localparam logic [3:0]  STEP_LAST   = 4'd15;

   typedef enum logic [1:0] {
      CMD_DIGIT  = 2'd0,
      CMD_OPER   = 2'd1,
      CMD_EQUALS = 2'd2,
      CMD_CLEAR  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      PEND_NONE = 3'd0,
      PEND_ADD  = 3'd1,
      PEND_SUB  = 3'd2,
      PEND_MUL  = 3'd3,
      PEND_DIV  = 3'd4
   } pend_type;

   typedef enum logic [2:0] {
      KEY_NOP    = 3'd0,
      KEY_DIGIT  = 3'd1,
      KEY_OPER   = 3'd2,
      KEY_EQUALS = 3'd3,
      KEY_CLEAR  = 3'd4
   } kind_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [3:0] digit;
      op_type     op;
   } req_word_type;

   typedef struct packed {
      logic [15:0] shown_value;
      logic [2:0]  ten_thousands;
      logic [3:0]  thousands;
      logic [3:0]  hundreds;
      logic [3:0]  tens;
      logic [3:0]  ones;
      logic [2:0]  digit_count;
   } rsp_word_type;

   // classified key as it travels from front to back
   typedef struct packed {
      kind_type   kind;
      logic [3:0] digit;
      op_type     op;
   } key_type;

endpackage

`default_nettype wire

// File: rtl/core/ffc_front.sv
// front end: accepts key words and classifies them
// depends on ffc_pkg
`default_nettype none

module ffc_front (
   input  wire                  req_valid,
   output logic                 req_ready,
   input  ffc_pkg::req_word_type req_word,
   input  wire                  q_full,
   output logic                 q_push,
   output ffc_pkg::key_type     q_key
);
   import ffc_pkg::*;

   assign req_ready = !q_full;
   assign q_push    = req_valid && req_ready;

   always_comb begin
      q_key.digit = req_word.digit;
      q_key.op    = req_word.op;
      unique case (req_word.cmd)
         CMD_DIGIT: begin
            // a digit above nine is dropped but still reports the display
            q_key.kind = (req_word.digit <= MAX_DIGIT) ? KEY_DIGIT : KEY_NOP;
         end
         CMD_OPER:   q_key.kind = KEY_OPER;
         CMD_EQUALS: q_key.kind = KEY_EQUALS;
         CMD_CLEAR:  q_key.kind = KEY_CLEAR;
         default:    q_key.kind = KEY_NOP;
      endcase
   end

endmodule

`default_nettype wire

// File: rtl/core/ffc_queue.sv
// short key queue between front and back
// depends on ffc_pkg and four_function_calculator_defines.svh
`default_nettype none
`include "four_function_calculator_defines.svh"

module ffc_queue #(
   parameter int unsigned Depth = ffc_pkg::QUEUE_DEPTH
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              push,
   input  ffc_pkg::key_type push_key,
   input  wire              pop,
   output logic             head_valid,
   output ffc_pkg::key_type head_key,
   output logic             full
);
   import ffc_pkg::*;

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] CntFull = CntW'(Depth);

   key_type         slot_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   assign full       = (count_ff == CntFull);
   assign head_valid = (count_ff != '0);
   assign head_key   = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_key;
      end
   end

   `FFC_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CntFull, "queue overfilled")
   `FFC_ASSERT_IMP(a_pop_nonempty, clock, reset, pop, count_ff != '0, "pop from empty queue")

endmodule

`default_nettype wire

// File: rtl/core/ffc_back.sv
// back end: calculator state, shift-add multiply, restoring divide,
// binary to decimal shifter and result register; depends on ffc_pkg
`default_nettype none
`include "four_function_calculator_defines.svh"

module ffc_back (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  head_valid,
   input  ffc_pkg::key_type     head_key,
   output logic                 pop,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output ffc_pkg::rsp_word_type rsp_word
);
   import ffc_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_MUL  = 5'b00010,
      S_DIV  = 5'b00100,
      S_CONV = 5'b01000,
      S_OUT  = 5'b10000
   } state_type;

   state_type    state_ff, state_in;
   logic [15:0]  display_ff, display_in;
   logic [15:0]  accum_ff, accum_in;
   pend_type     pend_ff, pend_in;
   logic         start_new_ff, start_new_in;
   kind_type     kind_ff, kind_in;
   op_type       op_ff, op_in;
   logic [3:0]   cnt_ff, cnt_in;
   logic [15:0]  wa_ff, wa_in;
   logic [15:0]  wb_ff, wb_in;
   logic [15:0]  prod_ff, prod_in;
   logic [15:0]  bin_ff, bin_in;
   logic [18:0]  bcd_ff, bcd_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   logic         fin_en;
   kind_type     fin_kind;
   op_type       fin_op;
   logic [15:0]  fin_val;
   logic         conv_start;
   logic [15:0]  base;
   logic [16:0]  trial;
   logic [18:0]  adj;
   logic         rsp_free;
   logic         back_idle;
   logic         mul_busy;
   logic         out_fire;
   logic         pend_legal;

   function automatic logic [3:0] dabble(input logic [3:0] d);
      dabble = (d >= 4'd5) ? d + 4'd3 : d;
   endfunction

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign back_idle = (state_ff == S_IDLE);
   assign pop       = back_idle && head_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;
   assign trial     = {wb_ff, wa_ff[15]} - {1'b0, display_ff};
   assign base      = start_new_ff ? '0 : display_ff;
   assign adj       = {bcd_ff[18:16], dabble(bcd_ff[15:12]), dabble(bcd_ff[11:8]),
                       dabble(bcd_ff[7:4]), dabble(bcd_ff[3:0])};

   always_comb begin
      state_in     = state_ff;
      display_in   = display_ff;
      accum_in     = accum_ff;
      pend_in      = pend_ff;
      start_new_in = start_new_ff;
      kind_in      = kind_ff;
      op_in        = op_ff;
      cnt_in       = cnt_ff;
      wa_in        = wa_ff;
      wb_in        = wb_ff;
      prod_in      = prod_ff;
      bin_in       = bin_ff;
      bcd_in       = bcd_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      fin_en       = 1'b0;
      fin_kind     = kind_ff;
      fin_op       = op_ff;
      fin_val      = display_ff;
      conv_start   = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (head_valid) begin
               kind_in  = head_key.kind;
               op_in    = head_key.op;
               fin_kind = head_key.kind;
               fin_op   = head_key.op;
               unique case (head_key.kind) inside
                  KEY_DIGIT: begin
                     start_new_in = 1'b0;
                     display_in   = base;
                     if (base <= DIGIT_LIMIT) begin
                        display_in = {base[12:0], 3'b000} + {base[14:0], 1'b0}
                                   + {12'd0, head_key.digit};
                     end
                     conv_start = 1'b1;
                  end
                  KEY_CLEAR: begin
                     display_in   = '0;
                     accum_in     = '0;
                     pend_in      = PEND_NONE;
                     start_new_in = 1'b1;
                     conv_start   = 1'b1;
                  end
                  KEY_OPER, KEY_EQUALS: begin
                     case (pend_ff)
                        PEND_ADD: begin
                           fin_en  = 1'b1;
                           fin_val = accum_ff + display_ff;
                        end
                        PEND_SUB: begin
                           fin_en  = 1'b1;
                           fin_val = accum_ff - display_ff;
                        end
                        PEND_MUL: begin
                           wa_in    = accum_ff;
                           wb_in    = display_ff;
                           prod_in  = '0;
                           cnt_in   = '0;
                           state_in = S_MUL;
                        end
                        PEND_DIV: begin
                           if (display_ff != '0) begin
                              wa_in    = accum_ff;
                              wb_in    = '0;
                              cnt_in   = '0;
                              state_in = S_DIV;
                           end else begin
                              fin_en = 1'b1;
                           end
                        end
                        default: fin_en = 1'b1;
                     endcase
                  end
                  default: conv_start = 1'b1;
               endcase
            end
         end
         S_MUL: begin
            // low half of the product, one multiplier bit a cycle
            prod_in = wb_ff[0] ? prod_ff + wa_ff : prod_ff;
            wa_in   = {wa_ff[14:0], 1'b0};
            wb_in   = {1'b0, wb_ff[15:1]};
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == STEP_LAST) begin
               fin_en  = 1'b1;
               fin_val = prod_in;
            end
         end
         S_DIV: begin
            // restoring divide: wa shifts dividend out and quotient in
            if (!trial[16]) begin
               wb_in = trial[15:0];
               wa_in = {wa_ff[14:0], 1'b1};
            end else begin
               wb_in = {wb_ff[14:0], wa_ff[15]};
               wa_in = {wa_ff[14:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == STEP_LAST) begin
               fin_en  = 1'b1;
               fin_val = wa_in;
            end
         end
         S_CONV: begin
            bcd_in = {adj[17:0], bin_ff[15]};
            bin_in = {bin_ff[14:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == STEP_LAST) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_free) begin
               rsp_word_in.shown_value   = display_ff;
               rsp_word_in.ten_thousands = bcd_ff[18:16];
               rsp_word_in.thousands     = bcd_ff[15:12];
               rsp_word_in.hundreds      = bcd_ff[11:8];
               rsp_word_in.tens          = bcd_ff[7:4];
               rsp_word_in.ones          = bcd_ff[3:0];
               if (bcd_ff[18:16] != '0) begin
                  rsp_word_in.digit_count = 3'd5;
               end else if (bcd_ff[15:12] != '0) begin
                  rsp_word_in.digit_count = 3'd4;
               end else if (bcd_ff[11:8] != '0) begin
                  rsp_word_in.digit_count = 3'd3;
               end else if (bcd_ff[7:4] != '0) begin
                  rsp_word_in.digit_count = 3'd2;
               end else begin
                  rsp_word_in.digit_count = 3'd1;
               end
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // completion of an operator or equals key
      if (fin_en) begin
         display_in   = fin_val;
         start_new_in = 1'b1;
         if (fin_kind == KEY_OPER) begin
            accum_in = fin_val;
            pend_in  = pend_type'({1'b0, fin_op} + 3'd1);
         end else begin
            pend_in = PEND_NONE;
         end
         conv_start = 1'b1;
      end

      if (conv_start) begin
         bin_in   = display_in;
         bcd_in   = '0;
         cnt_in   = '0;
         state_in = S_CONV;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         display_ff   <= '0;
         accum_ff     <= '0;
         pend_ff      <= PEND_NONE;
         start_new_ff <= 1'b1;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         display_ff   <= display_in;
         accum_ff     <= accum_in;
         pend_ff      <= pend_in;
         start_new_ff <= start_new_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      op_ff       <= op_in;
      wa_ff       <= wa_in;
      wb_ff       <= wb_in;
      prod_ff     <= prod_in;
      bin_ff      <= bin_in;
      bcd_ff      <= bcd_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign mul_busy   = (state_ff == S_MUL) && (cnt_ff != STEP_LAST);
   assign out_fire   = (state_ff == S_OUT) && rsp_free;
   assign pend_legal = (pend_ff == PEND_NONE) || (pend_ff == PEND_ADD)
                       || (pend_ff == PEND_SUB) || (pend_ff == PEND_MUL)
                       || (pend_ff == PEND_DIV);

   `FFC_ASSERT_NXT(a_mul_holds, clock, reset, mul_busy, state_ff == S_MUL, "multiply left early")
   `FFC_ASSERT_IMP(a_pend_legal, clock, reset, 1'b1, pend_legal, "bad pending code")
   `FFC_ASSERT_NXT(a_out_load, clock, reset, out_fire, rsp_valid_ff && back_idle, "word lost")

endmodule

`default_nettype wire

// File: rtl/core/four_function_calculator.sv
// a key word goes through the queue, the back end's state update, the shared
// shift-add / restoring divide unit when a multiply or divide completes, the
// 16-step binary to decimal shifter and the output register; the back end takes
// a new key only after parking its word, and parks it only once rsp is free
// reset: synchronous, clears display, accumulator, pending op and queue
`default_nettype none

// top level: front classifier, key queue, back execution unit
// depends on ffc_pkg, ffc_front, ffc_queue, ffc_back
module four_function_calculator #(
   parameter int unsigned QueueDepth = ffc_pkg::QUEUE_DEPTH
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  ffc_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output ffc_pkg::rsp_word_type rsp_word
);
   import ffc_pkg::*;

   // front to queue
   logic    q_push;
   key_type q_key;
   logic    q_full;

   // queue to back
   logic    head_valid;
   key_type head_key;
   logic    head_pop;

   // front takes a word whenever the queue has room, even while the back
   // is busy or a finished result still waits on the rsp side
   ffc_front u_front (
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_key     (q_key)
   );

   // decouples key entry from execution
   ffc_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_key   (q_key),
      .pop        (head_pop),
      .head_valid (head_valid),
      .head_key   (head_key),
      .full       (q_full)
   );

   // one key at a time: update state, run mul/div if pending, convert
   // to decimal, then park the word in the output register
   ffc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_key   (head_key),
      .pop        (head_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_word   (rsp_word)
   );

endmodule

`default_nettype wire
